// ===== rtl/sbp_pkg.sv =====
// sbp_pkg: shared types, constants and helpers for the segment bit packer
// used by sbp_cfg, sbp_engine and segment_bit_packer_core; no dependencies
package sbp_pkg;

    localparam int MAX_SEGMENT_BITS = 384;
    localparam int MIN_SEGMENT_BITS = 2;

    localparam int ZW    = 9;   // segment length width
    localparam int CBW   = 14;  // codeblock length width
    localparam int CFG_W = 14;  // widest register
    localparam int IDX_W = 2;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_SEGMENT_BITS   = 2'd0,
        REG_CODEBLOCK_BITS = 2'd1,
        REG_DIRECTION      = 2'd2
    } reg_index_t;

    localparam logic DIR_GATHER  = 1'b0;
    localparam logic DIR_SCATTER = 1'b1;

    typedef struct packed {
        logic [ZW-1:0]  z;       // clamped segment length
        logic [CBW-1:0] cb;      // codeblock length
        logic           scatter;
        logic           empty;   // no whole segment fits the block
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       eob;
        logic       last;
    } res_t;

    // low k bits set, all eight for k of 8 or more
    function automatic logic [7:0] low_mask(input logic [4:0] k);
        logic [7:0] m;
        if (k >= 5'd8)
        begin
            m = 8'hFF;
        end
        else
        begin
            m = (8'h01 << k[2:0]) - 8'h01;
        end
        return m;
    endfunction

endpackage

// ===== rtl/sbp_cfg.sv =====
// sbp_cfg: configuration registers with segment length clamping
// depends on sbp_pkg
module sbp_cfg
    import sbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg,
    output logic             clear
);

    logic [ZW-1:0]  z_reg;
    logic [ZW-1:0]  z_next;
    logic [CBW-1:0] cb_reg;
    logic [CBW-1:0] cb_next;
    logic           dir_reg;
    logic           dir_next;
    logic [ZW-1:0]  z_raw;

    always_comb
    begin
        z_raw    = cfg_data[ZW-1:0];
        z_next   = z_reg;
        cb_next  = cb_reg;
        dir_next = dir_reg;
        clear    = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SEGMENT_BITS:
                begin
                    if (z_raw < ZW'(MIN_SEGMENT_BITS))
                    begin
                        z_next = ZW'(MIN_SEGMENT_BITS);
                    end
                    else if (z_raw > ZW'(MAX_SEGMENT_BITS))
                    begin
                        z_next = ZW'(MAX_SEGMENT_BITS);
                    end
                    else
                    begin
                        z_next = z_raw;
                    end
                    clear = 1'b1;
                end
                REG_CODEBLOCK_BITS:
                begin
                    cb_next = cfg_data[CBW-1:0];
                    clear   = 1'b1;
                end
                REG_DIRECTION:
                begin
                    dir_next = cfg_data[0];
                    clear    = 1'b1;
                end
                default:
                begin
                    clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg   <= ZW'(MIN_SEGMENT_BITS);
            cb_reg  <= '0;
            dir_reg <= DIR_SCATTER;
        end
        else
        begin
            z_reg   <= z_next;
            cb_reg  <= cb_next;
            dir_reg <= dir_next;
        end
    end

    assign cfg.z       = z_reg;
    assign cfg.cb      = cb_reg;
    assign cfg.scatter = (dir_reg == DIR_SCATTER);
    assign cfg.empty   = ({{(CBW-ZW){1'b0}}, z_reg} > cb_reg);

endmodule

// ===== rtl/sbp_engine.sv =====
// sbp_engine: bit buffer and segment/block counters, one result word per cycle
// while out_free is high; depends on sbp_pkg
module sbp_engine
    import sbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       clear,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       out_free,
    output logic       consume,
    output logic       res_valid,
    output res_t       res
);

    logic [15:0]    buf_reg;
    logic [15:0]    buf_next;
    logic [4:0]     fill_reg;
    logic [4:0]     fill_next;
    logic [ZW-1:0]  sdone_reg;
    logic [ZW-1:0]  sdone_next;
    logic [CBW-1:0] bdone_reg;
    logic [CBW-1:0] bdone_next;
    logic           fin_reg;
    logic           fin_next;
    logic           pend_reg;
    logic           pend_next;
    logic [1:0]     nres_reg;
    logic [1:0]     nres_next;
    logic           end_reg;
    logic           end_next;

    // working copy after taking in the new byte
    logic [15:0]    w_buf;
    logic [4:0]     w_fill;
    logic [ZW-1:0]  w_sdone;
    logic [CBW-1:0] w_bdone;
    logic           w_end;
    // after one extraction
    logic [15:0]    n_buf;
    logic [4:0]     n_fill;
    logic [ZW-1:0]  n_sdone;
    logic [CBW-1:0] n_bdone;
    logic           n_fin;

    logic           fresh;
    logic           blocked;
    logic [ZW-1:0]  r0;
    logic [3:0]     k0;
    logic [7:0]     masked;
    logic [ZW-1:0]  sd0;
    logic [CBW:0]   bd0;
    logic [ZW-1:0]  r1;
    logic [3:0]     k1;
    logic [ZW-1:0]  sd1;
    logic [CBW:0]   bd1;
    logic [ZW-1:0]  r2;
    logic [3:0]     k2;
    logic           ok;
    logic           more;
    logic           eos;
    logic           eob;
    logic [7:0]     b;

    always_comb
    begin
        fresh   = !pend_reg && in_valid;
        blocked = fin_reg || cfg.empty;
        r0      = cfg.z - sdone_reg;
        k0      = (r0 < ZW'(8)) ? r0[3:0] : 4'd8;
        masked  = in_byte & low_mask({1'b0, k0});
        sd0     = sdone_reg + {{(ZW-4){1'b0}}, k0};
        bd0     = {1'b0, bdone_reg} + {{(CBW+1-ZW){1'b0}}, cfg.z};

        // take in the new byte
        w_buf   = buf_reg;
        w_fill  = fill_reg;
        w_sdone = sdone_reg;
        w_bdone = bdone_reg;
        w_end   = end_reg;
        if (!pend_reg)
        begin
            w_end = 1'b0;
            if (cfg.scatter)
            begin
                w_buf  = buf_reg | ({8'h00, in_byte} << fill_reg);
                w_fill = fill_reg + 5'd8;
            end
            else
            begin
                w_buf  = buf_reg | ({8'h00, masked} << fill_reg);
                w_fill = fill_reg + {1'b0, k0};
                if (sd0 >= cfg.z)
                begin
                    w_sdone = '0;
                    w_bdone = bd0[CBW-1:0];
                    w_end   = ({1'b0, bd0} + {{(CBW+2-ZW){1'b0}}, cfg.z})
                              > {2'b00, cfg.cb};
                end
                else
                begin
                    w_sdone = sd0;
                end
            end
        end

        // one extraction
        r1      = cfg.z - w_sdone;
        k1      = (r1 < ZW'(8)) ? r1[3:0] : 4'd8;
        sd1     = w_sdone + {{(ZW-4){1'b0}}, k1};
        bd1     = {1'b0, w_bdone} + {{(CBW+1-ZW){1'b0}}, cfg.z};
        n_buf   = w_buf;
        n_fill  = w_fill;
        n_sdone = w_sdone;
        n_bdone = w_bdone;
        n_fin   = fin_reg;
        eos     = 1'b0;
        eob     = 1'b0;
        b       = 8'h00;
        ok      = 1'b0;
        more    = 1'b0;
        r2      = '0;
        k2      = 4'd0;
        if (cfg.scatter)
        begin
            ok     = (w_fill >= {1'b0, k1});
            b      = w_buf[7:0] & low_mask({1'b0, k1});
            n_buf  = w_buf >> k1;
            n_fill = w_fill - {1'b0, k1};
            eos    = (sd1 >= cfg.z);
            if (eos)
            begin
                n_sdone = '0;
                n_bdone = bd1[CBW-1:0];
                eob     = ({1'b0, bd1} + {{(CBW+2-ZW){1'b0}}, cfg.z})
                          > {2'b00, cfg.cb};
            end
            else
            begin
                n_sdone = sd1;
            end
            if (eob)
            begin
                n_buf  = '0;
                n_fill = '0;
                n_fin  = 1'b1;
            end
            r2   = cfg.z - n_sdone;
            k2   = (r2 < ZW'(8)) ? r2[3:0] : 4'd8;
            more = !eob && (nres_reg != 2'd3) && (n_fill >= {1'b0, k2});
        end
        else
        begin
            if (w_fill >= 5'd8)
            begin
                ok     = 1'b1;
                b      = w_buf[7:0];
                n_buf  = w_buf >> 8;
                n_fill = w_fill - 5'd8;
                eob    = w_end && (n_fill == 5'd0);
            end
            else if (w_end && (w_fill != 5'd0))
            begin
                ok     = 1'b1;
                b      = w_buf[7:0] & low_mask(w_fill);
                n_buf  = '0;
                n_fill = '0;
                eob    = 1'b1;
            end
            more = (nres_reg != 2'd3)
                   && ((n_fill >= 5'd8) || (w_end && (n_fill != 5'd0)));
            // block end: clear once the item is spent
            if (w_end && !more)
            begin
                n_buf  = '0;
                n_fill = '0;
                n_fin  = 1'b1;
            end
        end

        // commit
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        sdone_next = sdone_reg;
        bdone_next = bdone_reg;
        fin_next   = fin_reg;
        pend_next  = pend_reg;
        nres_next  = nres_reg;
        end_next   = end_reg;
        consume    = 1'b0;
        res_valid  = 1'b0;
        if (fresh && blocked)
        begin
            consume = 1'b1;
        end
        else if (pend_reg || fresh)
        begin
            if (ok)
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    consume    = fresh;
                    buf_next   = n_buf;
                    fill_next  = n_fill;
                    sdone_next = n_sdone;
                    bdone_next = n_bdone;
                    fin_next   = n_fin;
                    pend_next  = more;
                    nres_next  = more ? nres_reg + 2'd1 : 2'd0;
                    end_next   = more ? w_end : 1'b0;
                end
            end
            else
            begin
                // item gives no word
                consume    = fresh;
                buf_next   = n_buf;
                fill_next  = n_fill;
                sdone_next = w_sdone;
                bdone_next = w_bdone;
                fin_next   = n_fin;
                pend_next  = 1'b0;
                nres_next  = 2'd0;
                end_next   = 1'b0;
            end
        end
        if (clear)
        begin
            buf_next   = '0;
            fill_next  = '0;
            sdone_next = '0;
            bdone_next = '0;
            fin_next   = 1'b0;
            pend_next  = 1'b0;
            nres_next  = 2'd0;
            end_next   = 1'b0;
        end
    end

    assign res.data = b;
    assign res.eos  = eos;
    assign res.eob  = eob;
    assign res.last = !more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            fill_reg  <= '0;
            sdone_reg <= '0;
            bdone_reg <= '0;
            fin_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            nres_reg  <= 2'd0;
            end_reg   <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            fill_reg  <= fill_next;
            sdone_reg <= sdone_next;
            bdone_reg <= bdone_next;
            fin_reg   <= fin_next;
            pend_reg  <= pend_next;
            nres_reg  <= nres_next;
            end_reg   <= end_next;
        end
    end

endmodule

// ===== rtl/segment_bit_packer_core.sv =====
// segment_bit_packer_core: top level of the segment bit packer
// depends on sbp_pkg, sbp_cfg and sbp_engine
//
// converts a packed lsb-first byte stream into z-bit segments (scatter) or
// segment bytes back into a packed stream (gather)
// s_* channel takes one byte per word; m_* channel gives one byte per word,
// tlast marks the final word of the codeblock, tuser carries segment end
// and the last word caused by one input byte
// cfg_we/cfg_index/cfg_data write segment length, codeblock length and
// direction; any valid write restarts the block, index 3 is ignored
// path: a byte accepted on s_* passes the input register, then the
// result register, before its first word shows on m_*
// throughput: one word per cycle while the result slot is free; a byte
// giving several words holds the input until its last word (up to four,
// with short scatter segments); the engine's single extraction step sets
// this; after the block end, bytes are taken and dropped with no word
// reset clears the stream state and loads z = 2, codeblock 0, scatter
// a stall on m_tready holds the result register, and the input register
// fills behind it, so s_tready drops one byte later
module segment_bit_packer_core
    import sbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // in_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast,   // end_of_block
    output logic [1:0]       m_tuser,   // [0] end_of_segment, [1] run_last
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t       cfg;
    logic       clear;
    logic       consume;
    logic       res_valid;
    res_t       res;
    logic       out_free;

    // input register
    logic       in_full_reg;
    logic       in_full_next;
    logic [7:0] in_byte_reg;
    logic       in_take;

    // result register
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       out_reg;

    sbp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .clear     (clear)
    );

    sbp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .clear     (clear),
        .in_valid  (in_full_reg),
        .in_byte   (in_byte_reg),
        .out_free  (out_free),
        .consume   (consume),
        .res_valid (res_valid),
        .res       (res)
    );

    // result slot frees when empty or taken this cycle
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready     = !in_full_reg || consume;
    assign in_take      = s_tvalid && s_tready;
    assign in_full_next = (in_full_reg && !consume) || in_take;

    assign out_valid_next = res_valid || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_tdata;
        end
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_reg.data;
    assign m_tlast    = out_reg.eob;
    assign m_tuser[0] = out_reg.eos;
    assign m_tuser[1] = out_reg.last;

endmodule

// ===== sim/sbp_stream_checker.sv =====
// sbp_stream_checker: watches the byte channels and register writes of the
// segment bit packer, predicts every result word and compares it in order
// depends on sbp_pkg for register indexes, widths and segment length limits
module sbp_stream_checker
    import sbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,   // in_byte
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [7:0]       m_tdata,   // out_byte
    input  logic             m_tlast,   // end_of_block
    input  logic [1:0]       m_tuser,   // [0] end_of_segment, [1] run_last
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output int               mismatches,
    output int               words_pending,
    output int               words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       eos;
        logic       eob;
        logic       last;
    } seg_word_t;

    logic [ZW-1:0]  seg_len;
    logic [CBW-1:0] block_len;
    logic           scatter;

    int unsigned    acc;
    int unsigned    acc_fill;
    int unsigned    seg_done;
    int unsigned    blk_done;
    logic           blk_closed;

    seg_word_t      due_words[$];

    function automatic logic [7:0] keep_bits(input int unsigned k);
        return (k >= 8) ? 8'hFF : 8'((1 << k) - 1);
    endfunction

    task automatic restart_block();
        acc        = 0;
        acc_fill   = 0;
        seg_done   = 0;
        blk_done   = 0;
        blk_closed = 1'b0;
    endtask

    task automatic flag_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
        mismatches++;
        $error("%s: expected %0h, got %0h", name, want, got);
    endtask

    // words one input byte gives, in either direction
    task automatic derive_words(input logic [7:0] b);
        seg_word_t   w[4];
        int          n;
        int unsigned z;
        int unsigned total;
        int unsigned r;
        int unsigned k;
        logic        ended;
        n     = 0;
        ended = 1'b0;
        z     = seg_len;
        if (z < MIN_SEGMENT_BITS)
            z = MIN_SEGMENT_BITS;
        if (z > MAX_SEGMENT_BITS)
            z = MAX_SEGMENT_BITS;
        total = (block_len / z) * z;
        if (blk_closed || total == 0)
            return;

        if (scatter == DIR_SCATTER)
        begin
            acc = (acc | (32'(b) << acc_fill)) & 32'hFFFF;
            acc_fill += 8;
            while (n < 4)
            begin
                r = z - seg_done;
                k = (r < 8) ? r : 8;
                if (acc_fill < k)
                    break;
                w[n].data = 8'(acc) & keep_bits(k);
                w[n].eos  = 1'b0;
                w[n].eob  = 1'b0;
                w[n].last = 1'b0;
                acc      = acc >> k;
                acc_fill -= k;
                seg_done += k;
                if (seg_done >= z)
                begin
                    w[n].eos = 1'b1;
                    seg_done = 0;
                    blk_done += z;
                    if (blk_done >= total)
                    begin
                        // leftover stream bits are dropped
                        w[n].eob   = 1'b1;
                        blk_closed = 1'b1;
                        acc        = 0;
                        acc_fill   = 0;
                    end
                end
                n++;
                if (w[n-1].eob)
                    break;
            end
        end
        else
        begin
            r = z - seg_done;
            k = (r < 8) ? r : 8;
            acc = (acc | (32'(b & keep_bits(k)) << acc_fill)) & 32'hFFFF;
            acc_fill += k;
            seg_done += k;
            if (seg_done >= z)
            begin
                seg_done = 0;
                blk_done += z;
                ended    = (blk_done >= total);
            end
            while (acc_fill >= 8 && n < 4)
            begin
                w[n].data = 8'(acc);
                acc       = acc >> 8;
                acc_fill -= 8;
                w[n].eos  = 1'b0;
                w[n].eob  = ended && (acc_fill == 0);
                w[n].last = 1'b0;
                n++;
            end
            // partial final byte goes out zero-filled
            if (ended && acc_fill > 0 && n < 4)
            begin
                w[n].data = 8'(acc) & keep_bits(acc_fill);
                w[n].eos  = 1'b0;
                w[n].eob  = 1'b1;
                w[n].last = 1'b0;
                n++;
            end
            if (ended)
            begin
                acc        = 0;
                acc_fill   = 0;
                blk_closed = 1'b1;
            end
        end

        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                w[i].last = 1'b1;
            due_words.push_back(w[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seg_word_t head;
        if (!rst_n)
        begin
            seg_len       = 9'd2;
            block_len     = '0;
            scatter       = DIR_SCATTER;
            restart_block();
            due_words.delete();
            mismatches    = 0;
            words_checked = 0;
            words_pending <= 0;
        end
        else
        begin
            // results first, so a word from nowhere is never hidden
            if (m_tvalid && m_tready)
            begin
                if (due_words.size() == 0)
                begin
                    mismatches++;
                    $error("word with nothing due: out_byte %0h", m_tdata);
                end
                else
                begin
                    head = due_words.pop_front();
                    words_checked++;
                    if (m_tdata !== head.data)
                        flag_field("out_byte", head.data, m_tdata);
                    if (m_tuser[0] !== head.eos)
                        flag_field("end_of_segment", 8'(head.eos), 8'(m_tuser[0]));
                    if (m_tlast !== head.eob)
                        flag_field("end_of_block", 8'(head.eob), 8'(m_tlast));
                    if (m_tuser[1] !== head.last)
                        flag_field("run_last", 8'(head.last), 8'(m_tuser[1]));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SEGMENT_BITS:
                    begin
                        seg_len = cfg_data[ZW-1:0];
                        restart_block();
                    end
                    REG_CODEBLOCK_BITS:
                    begin
                        block_len = cfg_data[CBW-1:0];
                        restart_block();
                    end
                    REG_DIRECTION:
                    begin
                        scatter = cfg_data[0];
                        restart_block();
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (s_tvalid && s_tready)
                derive_words(s_tdata);

            words_pending <= due_words.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: stimulus and verdict for segment_bit_packer_core
// depends on sbp_pkg, the block itself and sbp_stream_checker
module tb_top
    import sbp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // index past the register list, must be ignored by the block
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam int TOTAL_ITEMS    = 310;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES  = 4;   // input register plus result register, with margin

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic [1:0]       m_tuser;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               mismatches;
    int               words_pending;
    int               words_checked;

    // idle rates in percent; receiver rate is read on clock edges, so set by nba
    int               tx_gap_pct  = 15;
    int               rx_idle_pct = 24;
    // long holds asked for by the stimulus and served by the receiver
    int               rx_holds_asked = 0;
    int               rx_holds_done  = 0;

    int               items_sent  = 0;
    int               blocks_run  = 0;

    always #10 clk = ~clk;

    segment_bit_packer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sbp_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending),
        .words_checked (words_checked)
    );

    function automatic int clamp_len(input int z);
        if (z < MIN_SEGMENT_BITS)
            return MIN_SEGMENT_BITS;
        if (z > MAX_SEGMENT_BITS)
            return MAX_SEGMENT_BITS;
        return z;
    endfunction

    // input bytes that carry a whole block through to its end
    function automatic int bytes_for_block(input int z, input int cb, input logic dir);
        int ze;
        int nseg;
        ze   = clamp_len(z);
        nseg = cb / ze;
        if (dir == DIR_SCATTER)
            return (nseg * ze + 7) / 8;
        return nseg * ((ze + 7) / 8);
    endfunction

    // raises the write enable and waits for the edge that takes the write; the caller lowers it after the last one
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // writes all three registers, which also starts a fresh block
    task automatic set_block(input int z, input int cb, input logic dir);
        write_reg(REG_SEGMENT_BITS, CFG_W'(z));
        write_reg(REG_CODEBLOCK_BITS, CFG_W'(cb));
        write_reg(REG_DIRECTION, CFG_W'(dir));
        cfg_we <= 1'b0;
        blocks_run++;
    endtask

    // offers one word, maybe after a short gap, and returns on the accepting edge
    task automatic push_byte(input logic [7:0] v);
        if ($urandom_range(99) < tx_gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // sender stops until every predicted word has come back, then lets the
    // pipeline settle since a byte with no word may still be in flight
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_block(input int z, input int cb, input logic dir,
                             input int count, input int extra);
        set_block(z, cb, dir);
        repeat (count + extra) push_byte(8'($urandom));
        drain();
    endtask

    // random settings: mostly short segments and blocks, a few of the largest,
    // some with no whole segment and some long blocks left unfinished
    task automatic run_random_blocks();
        int   z;
        int   ze;
        int   cb;
        int   count;
        int   extra;
        int   pick;
        logic dir;
        while (items_sent < TOTAL_ITEMS)
        begin
            dir  = logic'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 10)
                z = $urandom_range(3);
            else if (pick < 22)
                z = $urandom_range(200, 511);
            else
                z = $urandom_range(2, 24);
            ze   = clamp_len(z);

            pick = $urandom_range(99);
            if (pick < 8)
                cb = $urandom_range(ze - 1);
            else if (pick < 12)
                cb = 16383;
            else
                cb = ((ze > 100) ? 1 : $urandom_range(1, 6)) * ze + $urandom_range(ze - 1);

            count = (cb == 16383) ? $urandom_range(8, 24) : bytes_for_block(z, cb, dir);
            // bytes after the block end only check that they are dropped
            extra = ($urandom_range(99) < 30) ? $urandom_range(1, 3) : 0;
            if (count == 0 && extra == 0)
                extra = 1;
            run_block(z, cb, dir, count, extra);
        end
    endtask

    // receiver: random stalls, plus one long hold counted here on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_holds_asked != rx_holds_done)
            begin
                rx_holds_done++;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial
    begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: scatter with an empty codeblock, nothing comes out
        push_byte(8'hA5);
        drain();

        // two byte-wide segments from all-zero and all-one bytes, then a byte
        // after the block end which must vanish
        set_block(8, 16, DIR_SCATTER);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h3C);
        drain();

        // gather of three 3-bit segments: high bits masked, partial byte flushed
        set_block(3, 9, DIR_GATHER);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        drain();

        // write past the register list leaves the finished block alone
        write_reg(REG_UNMAPPED, 14'h3FFF);
        cfg_we <= 1'b0;
        push_byte(8'h55);
        drain();

        // segment length below the minimum acts as two: four words from one byte
        set_block(1, 8, DIR_SCATTER);
        push_byte(8'hFF);
        push_byte(8'h81);
        drain();

        set_block(0, 3, DIR_SCATTER);
        push_byte(8'h02);
        drain();

        // oversize segment length with the longest codeblock, left unfinished
        set_block(511, 16383, DIR_SCATTER);
        push_byte(8'h80);
        push_byte(8'h01);
        push_byte(8'hFE);
        drain();

        // gather with a segment ending mid-byte, block end on a full byte
        set_block(12, 24, DIR_GATHER);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        drain();

        // codeblock shorter than one segment
        set_block(20, 19, DIR_SCATTER);
        push_byte(8'hC3);
        drain();

        // a stretch with no idling on either side
        tx_gap_pct  = 0;
        rx_idle_pct <= 0;
        run_block(13, 13 * 8, DIR_GATHER, bytes_for_block(13, 13 * 8, DIR_GATHER), 0);

        // receiver holds off while shortest segments fan each byte into four
        // words, so the block fills and stalls its input
        rx_holds_asked++;
        run_block(2, 256, DIR_SCATTER, bytes_for_block(2, 256, DIR_SCATTER), 0);

        tx_gap_pct  = 15;
        rx_idle_pct <= 24;
        run_random_blocks();

        repeat (8) @(posedge clk);

        $display("covered %0d input words over %0d register settings, %0d result words checked",
                 items_sent, blocks_run, words_checked);
        $display("both directions, clamped and extreme segment lengths, empty and unfinished blocks");
        if (mismatches == 0 && words_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
